// ===== rtl/core/assert_macros.svh =====
// assertion macros for the checker file nsfc_checker.sv
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, disabled while reset is asserted (active low)
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed: label");

// concurrent assertion that is also checked during reset
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed: label");

`endif

// ===== rtl/core/nsfc_pkg.sv =====
// shared types, constants and a lookup function for the nmea sentence framer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nsfc_pkg;

    localparam int MAX_SENTENCE_BYTES = 128;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [23:0] ID_GGA = 24'h474741;
    localparam logic [23:0] ID_RMC = 24'h524D43;
    localparam logic [23:0] ID_GSA = 24'h475341;
    localparam logic [23:0] ID_GSV = 24'h475356;
    localparam logic [23:0] ID_VTG = 24'h565447;

    localparam logic [2:0] ID_FULL_LEN = 3'd5;

    typedef enum logic [2:0] {
        CLS_START = 3'd0,
        CLS_END   = 3'd1,
        CLS_STAR  = 3'd2,
        CLS_COMMA = 3'd3,
        CLS_OTHER = 3'd4
    } t_cls;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_CKSUM = 2'd1,
        STAT_LONG  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        KIND_OTHER = 3'd0,
        KIND_GGA   = 3'd1,
        KIND_RMC   = 3'd2,
        KIND_GSA   = 3'd3,
        KIND_GSV   = 3'd4,
        KIND_VTG   = 3'd5
    } t_kind;

    // one classified byte as it travels from front to back
    typedef struct packed {
        t_cls       cls;
        logic [7:0] data;
        logic       hex_ok;
        logic [3:0] hex_val;
    } t_token;

    function automatic t_kind kind_of_tail(input logic [23:0] tail);
        t_kind k;
        case (tail)
            ID_GGA:  k = KIND_GGA;
            ID_RMC:  k = KIND_RMC;
            ID_GSA:  k = KIND_GSA;
            ID_GSV:  k = KIND_GSV;
            ID_VTG:  k = KIND_VTG;
            default: k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nsfc_front.sv =====
// front end: takes received bytes and classifies them into tokens
// depends on nsfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module nsfc_front (
    input  wire logic            i_rx_valid,
    output logic                 o_rx_ready,
    input  wire logic [7:0]      i_rx_byte,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output nsfc_pkg::t_token     o_token
);

    logic [7:0] w_c;

    assign w_c        = i_rx_byte;
    assign o_rx_ready = !i_q_full;
    assign o_push     = i_rx_valid && !i_q_full;

    always_comb begin
        o_token.data    = w_c;
        o_token.hex_ok  = 1'b0;
        o_token.hex_val = 4'd0;
        case (w_c)
            nsfc_pkg::CH_DOLLAR:                   o_token.cls = nsfc_pkg::CLS_START;
            nsfc_pkg::CH_CR, nsfc_pkg::CH_LF:      o_token.cls = nsfc_pkg::CLS_END;
            nsfc_pkg::CH_STAR:                     o_token.cls = nsfc_pkg::CLS_STAR;
            nsfc_pkg::CH_COMMA:                    o_token.cls = nsfc_pkg::CLS_COMMA;
            default:                               o_token.cls = nsfc_pkg::CLS_OTHER;
        endcase
        // hex digit in either case
        if (w_c inside {[8'h30:8'h39]}) begin
            o_token.hex_ok  = 1'b1;
            o_token.hex_val = w_c[3:0];
        end else if (w_c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            o_token.hex_ok  = 1'b1;
            o_token.hex_val = w_c[3:0] + 4'd9;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/nsfc_queue.sv =====
// short token queue between the front end and the sentence engine
// depends on nsfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module nsfc_queue #(
    parameter int DEPTH = nsfc_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire nsfc_pkg::t_token  i_token,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_pop,
    output nsfc_pkg::t_token       o_token
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    nsfc_pkg::t_token r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_do_push, w_do_pop;

    assign o_full    = (r_cnt == FULL);
    assign o_valid   = (r_cnt != '0);
    assign o_token   = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_do_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        case ({w_do_push, w_do_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_token;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/nsfc_back.sv =====
// sentence engine: framing, checksum, identifier capture, counters, result register
// depends on nsfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module nsfc_back #(
    parameter int MAX_SENTENCE_BYTES = nsfc_pkg::MAX_SENTENCE_BYTES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire nsfc_pkg::t_token  i_token,
    output logic                   o_pop,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output logic [1:0]             o_line_status,
    output logic [2:0]             o_sentence_kind,
    output logic [7:0]             o_talker_first,
    output logic [7:0]             o_talker_second,
    output logic [31:0]            o_good_total,
    output logic [31:0]            o_bad_total
);

    localparam int LW = $clog2(MAX_SENTENCE_BYTES);
    localparam logic [LW-1:0] LEN_LIMIT = LW'(MAX_SENTENCE_BYTES - 1);

    logic          r_in_frame, n_in_frame;
    logic          r_overlong, n_overlong;
    logic [LW-1:0] r_len, n_len;
    logic [7:0]    r_xor, n_xor;
    logic          r_star, n_star;
    logic [1:0]    r_digits, n_digits;
    logic [7:0]    r_ck, n_ck;
    logic          r_dig_inv, n_dig_inv;
    logic          r_id_closed, n_id_closed;
    logic [2:0]    r_id_len, n_id_len;
    logic [15:0]   r_head, n_head;
    logic [23:0]   r_tail, n_tail;
    logic [31:0]   r_good, n_good;
    logic [31:0]   r_bad, n_bad;

    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_status, n_status;
    logic [2:0]    r_kind, n_kind;
    logic [7:0]    r_t1, n_t1;
    logic [7:0]    r_t2, n_t2;

    logic          w_slot_free;
    logic [7:0]    w_c;

    assign w_slot_free = !r_out_valid || i_res_ready;
    assign o_pop       = i_q_valid && w_slot_free;
    assign w_c         = i_token.data;

    assign o_res_valid     = r_out_valid;
    assign o_line_status   = r_status;
    assign o_sentence_kind = r_kind;
    assign o_talker_first  = r_t1;
    assign o_talker_second = r_t2;
    assign o_good_total    = r_good;
    assign o_bad_total     = r_bad;

    always_comb begin
        n_in_frame  = r_in_frame;
        n_overlong  = r_overlong;
        n_len       = r_len;
        n_xor       = r_xor;
        n_star      = r_star;
        n_digits    = r_digits;
        n_ck        = r_ck;
        n_dig_inv   = r_dig_inv;
        n_id_closed = r_id_closed;
        n_id_len    = r_id_len;
        n_head      = r_head;
        n_tail      = r_tail;
        n_good      = r_good;
        n_bad       = r_bad;
        n_out_valid = r_out_valid && !i_res_ready;
        n_status    = r_status;
        n_kind      = r_kind;
        n_t1        = r_t1;
        n_t2        = r_t2;

        if (o_pop) begin
            if (i_token.cls == nsfc_pkg::CLS_START) begin
                n_in_frame  = 1'b1;
                n_overlong  = 1'b0;
                n_len       = '0;
                n_xor       = '0;
                n_star      = 1'b0;
                n_digits    = '0;
                n_ck        = '0;
                n_dig_inv   = 1'b0;
                n_id_closed = 1'b0;
                n_id_len    = '0;
                n_head      = '0;
                n_tail      = '0;
            end else if (r_in_frame) begin
                if (i_token.cls == nsfc_pkg::CLS_END) begin
                    n_kind = nsfc_pkg::KIND_OTHER;
                    n_t1   = '0;
                    n_t2   = '0;
                    if (r_overlong) begin
                        n_out_valid = 1'b1;
                        n_status    = nsfc_pkg::STAT_LONG;
                        n_bad       = r_bad + 32'd1;
                    end else if (r_len != '0) begin
                        n_out_valid = 1'b1;
                        if (r_star && r_digits == 2'd2 && !r_dig_inv && r_ck == r_xor) begin
                            n_status = nsfc_pkg::STAT_OK;
                            n_good   = r_good + 32'd1;
                            if (r_id_len >= nsfc_pkg::ID_FULL_LEN) begin
                                n_kind = nsfc_pkg::kind_of_tail(r_tail);
                                n_t1   = r_head[15:8];
                                n_t2   = r_head[7:0];
                            end
                        end else begin
                            n_status = nsfc_pkg::STAT_CKSUM;
                            n_bad    = r_bad + 32'd1;
                        end
                    end
                    n_in_frame  = 1'b0;
                    n_overlong  = 1'b0;
                    n_len       = '0;
                    n_xor       = '0;
                    n_star      = 1'b0;
                    n_digits    = '0;
                    n_ck        = '0;
                    n_dig_inv   = 1'b0;
                    n_id_closed = 1'b0;
                    n_id_len    = '0;
                    n_head      = '0;
                    n_tail      = '0;
                end else if (!r_overlong) begin
                    if (r_len >= LEN_LIMIT) begin
                        n_overlong = 1'b1;
                    end else begin
                        n_len = r_len + 1'b1;
                        if (!r_star) begin
                            if (i_token.cls == nsfc_pkg::CLS_STAR) begin
                                n_star      = 1'b1;
                                n_id_closed = 1'b1;
                            end else begin
                                n_xor = r_xor ^ w_c;
                                if (!r_id_closed) begin
                                    if (i_token.cls == nsfc_pkg::CLS_COMMA) begin
                                        n_id_closed = 1'b1;
                                    end else begin
                                        if (r_id_len == 3'd0) begin
                                            n_head = {w_c, 8'h00};
                                        end else if (r_id_len == 3'd1) begin
                                            n_head = {r_head[15:8], w_c};
                                        end
                                        n_tail = {r_tail[15:0], w_c};
                                        if (r_id_len < nsfc_pkg::ID_FULL_LEN) begin
                                            n_id_len = r_id_len + 3'd1;
                                        end
                                    end
                                end
                            end
                        end else if (r_digits < 2'd2) begin
                            if (!i_token.hex_ok) begin
                                n_dig_inv = 1'b1;
                            end else begin
                                n_ck = {r_ck[3:0], i_token.hex_val};
                            end
                            n_digits = r_digits + 2'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_overlong  <= 1'b0;
            r_len       <= '0;
            r_xor       <= '0;
            r_star      <= 1'b0;
            r_digits    <= '0;
            r_ck        <= '0;
            r_dig_inv   <= 1'b0;
            r_id_closed <= 1'b0;
            r_id_len    <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_good      <= '0;
            r_bad       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_frame  <= n_in_frame;
            r_overlong  <= n_overlong;
            r_len       <= n_len;
            r_xor       <= n_xor;
            r_star      <= n_star;
            r_digits    <= n_digits;
            r_ck        <= n_ck;
            r_dig_inv   <= n_dig_inv;
            r_id_closed <= n_id_closed;
            r_id_len    <= n_id_len;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_good      <= n_good;
            r_bad       <= n_bad;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_kind   <= n_kind;
        r_t1     <= n_t1;
        r_t2     <= n_t2;
    end

endmodule

`default_nettype wire

// ===== rtl/core/nmea_sentence_framer_checker.sv =====
// top level of the nmea 0183 sentence framer and checksum checker
// depends on nsfc_pkg, nsfc_front, nsfc_queue, nsfc_back
//
// usage
// - rx channel (i_rx_valid / o_rx_ready / i_rx_byte): one received character per word
// - result channel (o_res_valid / i_res_ready and the o_ result fields): one word at
//   the end of each non-empty sentence ('$' ... CR or LF); status, sentence kind,
//   talker characters and the running good and bad totals
// - bytes outside a sentence and an empty sentence give no result
// throughput and result path
// - one rx word per cycle while the queue has room; the engine retires one queued token a cycle
//   while its result slot is free; a result appears once its CR/LF word is queued and the engine
//   has then updated the result register from it, later if earlier words are still queued
// stalls
// - while a result word waits on the receiver the engine takes no further token; the
//   queue (QUEUE_DEPTH words) fills and only then does o_rx_ready drop
// reset
// - synchronous, active low; clears framing state, counters, queue and result valid;
//   the block takes words as soon as reset is released
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_framer_checker #(
    parameter int MAX_SENTENCE_BYTES = nsfc_pkg::MAX_SENTENCE_BYTES,
    parameter int QUEUE_DEPTH        = nsfc_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output logic [1:0]       o_line_status,
    output logic [2:0]       o_sentence_kind,
    output logic [7:0]       o_talker_first,
    output logic [7:0]       o_talker_second,
    output logic [31:0]      o_good_total,
    output logic [31:0]      o_bad_total
);

    nsfc_pkg::t_token w_push_token;
    nsfc_pkg::t_token w_pop_token;
    logic             w_push;
    logic             w_q_full;
    logic             w_q_valid;
    logic             w_pop;

    // classify each byte as it is taken
    nsfc_front u_front (
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_token    (w_push_token)
    );

    // decoupling queue so the engine can wait on the result receiver alone
    nsfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_token (w_push_token),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_token (w_pop_token)
    );

    // framing, checksum and counters, with the result register
    nsfc_back #(
        .MAX_SENTENCE_BYTES (MAX_SENTENCE_BYTES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_token         (w_pop_token),
        .o_pop           (w_pop),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_line_status   (o_line_status),
        .o_sentence_kind (o_sentence_kind),
        .o_talker_first  (o_talker_first),
        .o_talker_second (o_talker_second),
        .o_good_total    (o_good_total),
        .o_bad_total     (o_bad_total)
    );

endmodule

`default_nettype wire

// ===== rtl/core/nsfc_checker.sv =====
// port-level assertions for the sentence framer, with the bind to the top level
// depends on nsfc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nsfc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_rx_ready,
    input wire logic        o_res_valid,
    input wire logic        i_res_ready,
    input wire logic [1:0]  o_line_status,
    input wire logic [2:0]  o_sentence_kind,
    input wire logic [7:0]  o_talker_first,
    input wire logic [7:0]  o_talker_second,
    input wire logic [31:0] o_good_total,
    input wire logic [31:0] o_bad_total
);

    logic [31:0] r_last_sum;
    logic [31:0] w_sum;
    logic        w_rejected;
    logic        w_count_step;
    logic        w_id_clear;
    logic        w_stalled;
    logic [84:0] w_payload;

    assign w_sum        = o_good_total + o_bad_total;
    assign w_rejected   = (o_line_status != nsfc_pkg::STAT_OK);
    assign w_count_step = (w_sum == r_last_sum + 32'd1);
    assign w_id_clear   = (o_sentence_kind == nsfc_pkg::KIND_OTHER) &&
                          (o_talker_first == 8'd0) && (o_talker_second == 8'd0);
    assign w_stalled    = o_res_valid && !i_res_ready;
    assign w_payload    = {o_line_status, o_sentence_kind, o_talker_first, o_talker_second,
                           o_good_total, o_bad_total};

    // total of both counters at the last delivered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sum <= '0;
        end else if (o_res_valid && i_res_ready) begin
            r_last_sum <= w_sum;
        end
    end

    // each result moves exactly one counter by one
    `ASSERT_CLK_RST(a_one_count_per_result, i_clk, i_rst_n, o_res_valid |-> w_count_step)

    // rejected sentences carry no kind or talker
    `ASSERT_CLK_RST(a_reject_clears_id, i_clk, i_rst_n, (o_res_valid && w_rejected) |-> w_id_clear)

    // a stalled result word holds
    `ASSERT_CLK_RST(a_result_holds, i_clk, i_rst_n, w_stalled |=> (o_res_valid && $stable(w_payload)))

    // reset leaves no result pending and the rx side open
    `ASSERT_CLK(a_reset_clean, i_clk, !i_rst_n |=> (!o_res_valid && o_rx_ready))

endmodule

bind nmea_sentence_framer_checker nsfc_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_rx_ready      (o_rx_ready),
    .o_res_valid     (o_res_valid),
    .i_res_ready     (i_res_ready),
    .o_line_status   (o_line_status),
    .o_sentence_kind (o_sentence_kind),
    .o_talker_first  (o_talker_first),
    .o_talker_second (o_talker_second),
    .o_good_total    (o_good_total),
    .o_bad_total     (o_bad_total)
);

`default_nettype wire

// ===== verif/nsfc_line_checker.sv =====
// result checker for the nmea sentence framer: tracks sentence state from the rx words,
// queues the result words that must follow, compares them field by field
// depends on nsfc_pkg
`timescale 1ns / 1ps

module nsfc_line_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    input  logic        i_rx_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [1:0]  i_line_status,
    input  logic [2:0]  i_sentence_kind,
    input  logic [7:0]  i_talker_first,
    input  logic [7:0]  i_talker_second,
    input  logic [31:0] i_good_total,
    input  logic [31:0] i_bad_total,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_accepted
);

    typedef struct {
        nsfc_pkg::t_status status;
        nsfc_pkg::t_kind   kind;
        logic [7:0]        talker_a;
        logic [7:0]        talker_b;
        logic [31:0]       good;
        logic [31:0]       bad;
    } t_line_result;

    t_line_result expected_lines[$];

    // sentence tracking state
    logic        framing;
    logic        too_long;
    int unsigned body_len;
    logic [7:0]  xor_acc;
    logic        star_hit;
    logic [1:0]  ck_digits;
    logic [7:0]  ck_value;
    logic        ck_bad;
    logic        id_done;
    logic [2:0]  id_len;
    logic [15:0] id_head;
    logic [23:0] id_tail;
    logic [31:0] good_cnt;
    logic [31:0] bad_cnt;

    int fail_tally;
    int checked_tally;
    int accepted_tally;

    function automatic int hex_nibble(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") return int'(ch - "0");
        if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
        if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
        return -1;
    endfunction

    function automatic nsfc_pkg::t_kind tail_kind(input logic [23:0] tail);
        if (tail == "GGA") return nsfc_pkg::KIND_GGA;
        if (tail == "RMC") return nsfc_pkg::KIND_RMC;
        if (tail == "GSA") return nsfc_pkg::KIND_GSA;
        if (tail == "GSV") return nsfc_pkg::KIND_GSV;
        if (tail == "VTG") return nsfc_pkg::KIND_VTG;
        return nsfc_pkg::KIND_OTHER;
    endfunction

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t ns  mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        fail_tally++;
    endtask

    task restart_sentence();
        too_long  = 1'b0;
        body_len  = 0;
        xor_acc   = 8'h00;
        star_hit  = 1'b0;
        ck_digits = 2'd0;
        ck_value  = 8'h00;
        ck_bad    = 1'b0;
        id_done   = 1'b0;
        id_len    = 3'd0;
        id_head   = 16'h0000;
        id_tail   = 24'h000000;
    endtask

    // one body character: checksum fold, identifier capture or checksum digit
    task fold_body_char(input logic [7:0] ch);
        int nib;
        if (!star_hit) begin
            if (ch == nsfc_pkg::CH_STAR) begin
                star_hit = 1'b1;
                id_done  = 1'b1;
            end else begin
                xor_acc ^= ch;
                if (!id_done) begin
                    if (ch == nsfc_pkg::CH_COMMA) begin
                        id_done = 1'b1;
                    end else begin
                        if (id_len == 3'd0) id_head = {ch, 8'h00};
                        else if (id_len == 3'd1) id_head[7:0] = ch;
                        id_tail = {id_tail[15:0], ch};
                        if (id_len < nsfc_pkg::ID_FULL_LEN) id_len++;
                    end
                end
            end
        end else if (ck_digits < 2'd2) begin
            nib = hex_nibble(ch);
            if (nib < 0) ck_bad = 1'b1;
            else ck_value = {ck_value[3:0], nib[3:0]};
            ck_digits++;
        end
    endtask

    task take_rx_word(input logic [7:0] ch);
        t_line_result res;
        if (ch == nsfc_pkg::CH_DOLLAR) begin
            restart_sentence();
            framing = 1'b1;
        end else if (framing && (ch == nsfc_pkg::CH_CR || ch == nsfc_pkg::CH_LF)) begin
            if (too_long || body_len > 0) begin
                res.kind     = nsfc_pkg::KIND_OTHER;
                res.talker_a = 8'h00;
                res.talker_b = 8'h00;
                if (too_long) begin
                    res.status = nsfc_pkg::STAT_LONG;
                    bad_cnt++;
                end else if (star_hit && ck_digits == 2'd2 && !ck_bad && ck_value == xor_acc) begin
                    res.status = nsfc_pkg::STAT_OK;
                    good_cnt++;
                    if (id_len >= nsfc_pkg::ID_FULL_LEN) begin
                        res.kind     = tail_kind(id_tail);
                        res.talker_a = id_head[15:8];
                        res.talker_b = id_head[7:0];
                    end
                end else begin
                    res.status = nsfc_pkg::STAT_CKSUM;
                    bad_cnt++;
                end
                res.good = good_cnt;
                res.bad  = bad_cnt;
                expected_lines.push_back(res);
            end
            restart_sentence();
            framing = 1'b0;
        end else if (framing && !too_long) begin
            if (body_len + 1 >= nsfc_pkg::MAX_SENTENCE_BYTES) too_long = 1'b1;
            else begin
                body_len++;
                fold_body_char(ch);
            end
        end
    endtask

    task check_result_word();
        t_line_result want;
        if (expected_lines.size() == 0) begin
            report_mismatch("result word with nothing expected (status)", i_line_status, 0);
        end else begin
            want = expected_lines.pop_front();
            checked_tally++;
            if (want.status == nsfc_pkg::STAT_OK) accepted_tally++;
            if (i_line_status !== want.status)
                report_mismatch("line status", i_line_status, want.status);
            if (i_sentence_kind !== want.kind)
                report_mismatch("sentence kind", i_sentence_kind, want.kind);
            if (i_talker_first !== want.talker_a)
                report_mismatch("talker first", i_talker_first, want.talker_a);
            if (i_talker_second !== want.talker_b)
                report_mismatch("talker second", i_talker_second, want.talker_b);
            if (i_good_total !== want.good)
                report_mismatch("good total", i_good_total, want.good);
            if (i_bad_total !== want.bad)
                report_mismatch("bad total", i_bad_total, want.bad);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_sentence();
            framing        = 1'b0;
            good_cnt       = 32'd0;
            bad_cnt        = 32'd0;
            fail_tally     = 0;
            checked_tally  = 0;
            accepted_tally = 0;
            expected_lines.delete();
        end else begin
            if (i_res_valid && i_res_ready) check_result_word();
            if (i_rx_valid && i_rx_ready) take_rx_word(i_rx_byte);
        end
        // registered so the top never races the update above
        o_fail_count <= fail_tally;
        o_pending    <= expected_lines.size();
        o_checked    <= checked_tally;
        o_accepted   <= accepted_tally;
    end

endmodule

// ===== verif/tb_top.sv =====
// top of the nmea sentence framer testbench: clock, reset, rx word stimulus, result
// receiver with random stalls, watchdog and verdict; checking lives in nsfc_line_checker
// depends on nsfc_pkg, nsfc_line_checker and the nmea_sentence_framer_checker rtl
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_BYTES = 360;   // rough size of the random part, in rx words
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off to fill the block
    localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 12;

    // how a sentence closes its checksum field
    typedef enum int {
        CK_UPPER,
        CK_LOWER,
        CK_WRONG,
        CK_MISSING,
        CK_SHORT,
        CK_NONHEX
    } t_ck_mode;

    // how a sentence is terminated
    typedef enum int {
        END_CR,
        END_LF,
        END_CRLF,
        END_NONE
    } t_line_end;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_rx_valid;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte;
    logic        o_res_valid;
    logic        i_res_ready;
    logic [1:0]  o_line_status;
    logic [2:0]  o_sentence_kind;
    logic [7:0]  o_talker_first;
    logic [7:0]  o_talker_second;
    logic [31:0] o_good_total;
    logic [31:0] o_bad_total;

    int fail_count;
    int pending;
    int checked;
    int accepted;

    // knobs shared between the sender, the receiver and the sequence below
    bit tx_gaps;
    bit res_stalls;
    bit squeeze_req;
    bit squeeze_done;
    int bytes_sent;
    int quiet_cycles;

    // body text of the sentence being built, without '$', checksum or terminator
    logic [7:0] body_q[$];

    nmea_sentence_framer_checker DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_rx_valid),
        .o_rx_ready      (o_rx_ready),
        .i_rx_byte       (i_rx_byte),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_line_status   (o_line_status),
        .o_sentence_kind (o_sentence_kind),
        .o_talker_first  (o_talker_first),
        .o_talker_second (o_talker_second),
        .o_good_total    (o_good_total),
        .o_bad_total     (o_bad_total)
    );

    nsfc_line_checker line_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_rx_valid),
        .i_rx_ready      (o_rx_ready),
        .i_rx_byte       (i_rx_byte),
        .i_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .i_line_status   (o_line_status),
        .i_sentence_kind (o_sentence_kind),
        .i_talker_first  (o_talker_first),
        .i_talker_second (o_talker_second),
        .i_good_total    (o_good_total),
        .i_bad_total     (o_bad_total),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_accepted      (accepted)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // reset held at the start, never again
    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // watchdog: any handshake on either channel counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results still due",
                     QUIET_LIMIT, pending);
            $display("** nmea_sentence_framer_checker: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ascii hex digit in either case
    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return "0" + 8'(n);
        return (lower ? "a" : "A") + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] upper_char();
        return "A" + 8'($urandom_range(0, 25));
    endfunction

    // mostly printable field text, now and then any byte that neither starts nor ends a line
    function automatic logic [7:0] field_char();
        int r;
        logic [7:0] ch;
        r = $urandom_range(0, 99);
        if (r < 50) ch = "0" + 8'($urandom_range(0, 9));
        else if (r < 70) ch = upper_char();
        else if (r < 80) ch = ".";
        else if (r < 88) ch = "a" + 8'($urandom_range(0, 25));
        else begin
            ch = 8'($urandom_range(0, 255));
            if (ch == nsfc_pkg::CH_DOLLAR || ch == nsfc_pkg::CH_CR || ch == nsfc_pkg::CH_LF)
                ch = 8'h00;
        end
        return ch;
    endfunction

    // offer one rx word, with a random idle burst ahead of it when gaps are on
    task automatic send_byte(input logic [7:0] ch);
        int gap;
        if (tx_gaps && $urandom_range(0, 99) < 12) begin
            gap = $urandom_range(1, 11);
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= ch;
        do @(posedge i_clk); while (!o_rx_ready);
        bytes_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
    endtask

    // frame the body in body_q: '$', body, checksum field, optional junk, terminator
    task automatic send_sentence(input t_ck_mode mode, input bit junk, input t_line_end term);
        logic [7:0] fold;
        logic [7:0] sent;
        bit lower;
        fold = 8'h00;
        foreach (body_q[i]) fold ^= body_q[i];
        send_byte(nsfc_pkg::CH_DOLLAR);
        foreach (body_q[i]) send_byte(body_q[i]);
        case (mode)
            CK_UPPER, CK_LOWER, CK_WRONG: begin
                sent  = (mode == CK_WRONG) ? fold ^ 8'($urandom_range(1, 255)) : fold;
                lower = (mode == CK_LOWER);
                send_byte(nsfc_pkg::CH_STAR);
                send_byte(hex_char(sent[7:4], lower));
                send_byte(hex_char(sent[3:0], lower));
            end
            CK_SHORT: begin
                send_byte(nsfc_pkg::CH_STAR);
                send_byte(hex_char(fold[7:4], 1'b0));
            end
            CK_NONHEX: begin
                // a letter past 'F' in either digit position
                send_byte(nsfc_pkg::CH_STAR);
                if ($urandom_range(0, 1)) begin
                    send_byte("G" + 8'($urandom_range(0, 19)));
                    send_byte(hex_char(fold[3:0], 1'b0));
                end else begin
                    send_byte(hex_char(fold[7:4], 1'b1));
                    send_byte("g" + 8'($urandom_range(0, 19)));
                end
            end
            default: ;
        endcase
        if (junk) repeat ($urandom_range(1, 3)) send_byte(field_char());
        case (term)
            END_CR: send_byte(nsfc_pkg::CH_CR);
            END_LF: send_byte(nsfc_pkg::CH_LF);
            END_CRLF: begin
                send_byte(nsfc_pkg::CH_CR);
                send_byte(nsfc_pkg::CH_LF);
            end
            default: ;
        endcase
        body_q.delete();
    endtask

    task automatic send_text(input string text, input t_ck_mode mode, input t_line_end term);
        add_text(text);
        send_sentence(mode, 1'b0, term);
    endtask

    // talker plus a known or random three-letter kind most of the time, otherwise zero to seven random letters
    task automatic random_ident();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
            if (pick < 3) add_text("GP");
            else if (pick < 6) add_text("GN");
            else repeat (2) body_q.push_back(upper_char());
            case ($urandom_range(0, 5))
                0: add_text("GGA");
                1: add_text("RMC");
                2: add_text("GSA");
                3: add_text("GSV");
                4: add_text("VTG");
                default: repeat (3) body_q.push_back(upper_char());
            endcase
        end else begin
            repeat ($urandom_range(0, 7)) body_q.push_back(upper_char());
        end
    endtask

    task automatic random_sentence(input bit well_formed);
        int pick;
        t_ck_mode mode;
        t_line_end term;
        bit junk;
        pick = $urandom_range(0, 99);
        if (!well_formed && pick < 5) begin
            // long enough to reach the length limit once a full checksum field is added
            repeat ($urandom_range(125, 140)) body_q.push_back(field_char());
        end else begin
            random_ident();
            repeat ($urandom_range(0, 5)) begin
                body_q.push_back(nsfc_pkg::CH_COMMA);
                repeat ($urandom_range(0, 6)) body_q.push_back(field_char());
            end
        end
        pick = $urandom_range(0, 99);
        if (well_formed || pick < 35) mode = CK_UPPER;
        else if (pick < 70) mode = CK_LOWER;
        else if (pick < 80) mode = CK_WRONG;
        else if (pick < 85) mode = CK_MISSING;
        else if (pick < 90) mode = CK_SHORT;
        else mode = CK_NONHEX;
        junk = !well_formed && ($urandom_range(0, 9) == 0);
        pick = $urandom_range(0, 99);
        if (well_formed || pick < 45) term = END_CR;
        else if (pick < 80) term = END_LF;
        else if (pick < 97) term = END_CRLF;
        else term = END_NONE;
        send_sentence(mode, junk, term);
    endtask

    // result receiver: random stall bursts, one long hold-off on request
    initial begin
        i_res_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (squeeze_req && !squeeze_done) begin
                i_res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                squeeze_done = 1'b1;
            end else if (res_stalls && $urandom_range(0, 99) < 15) begin
                i_res_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                i_res_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // stimulus and verdict
    initial begin
        int start_bytes;
        int offset;
        i_rx_valid   = 1'b0;
        i_rx_byte    = 8'h00;
        tx_gaps      = 1'b1;
        res_stalls   = 1'b1;
        squeeze_req  = 1'b0;
        squeeze_done = 1'b0;
        bytes_sent   = 0;
        quiet_cycles = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        // directed: stray words outside a sentence, then empty sentences
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(nsfc_pkg::CH_STAR);
        send_byte(nsfc_pkg::CH_CR);
        send_byte(nsfc_pkg::CH_DOLLAR);
        send_byte(nsfc_pkg::CH_CR);
        send_byte(nsfc_pkg::CH_DOLLAR);
        send_byte(nsfc_pkg::CH_LF);

        // every known kind, both hex cases, all terminators
        send_text("GPGGA,123519,4807.038,N", CK_UPPER, END_CR);
        send_text("GNRMC,A,1.5", CK_LOWER, END_LF);
        send_text("GPGSA,A,3", CK_UPPER, END_CRLF);
        send_text("GLGSV,2,1,08", CK_UPPER, END_CR);
        send_text("GPVTG,054.7,T", CK_LOWER, END_CR);
        // unknown kind, identifier longer than five, too short, no comma, empty, comma first
        send_text("GPXYZ,1", CK_UPPER, END_CR);
        send_text("ABCDEFGGA,7", CK_UPPER, END_CR);
        send_text("GGA,1", CK_UPPER, END_LF);
        send_text("GPRMC", CK_UPPER, END_CR);
        send_text("", CK_UPPER, END_CR);
        send_text(",1,2", CK_LOWER, END_CR);
        // checksum wrong, missing, one digit only, not hex
        send_text("GPGGA,1", CK_WRONG, END_CR);
        send_text("GPGGA,2", CK_MISSING, END_CR);
        send_text("GPGSV,3", CK_SHORT, END_LF);
        send_text("GPGSA,4", CK_NONHEX, END_CR);
        // characters after the checksum, nul and all-ones bytes inside the body
        add_text("GPVTG,5");
        send_sentence(CK_UPPER, 1'b1, END_CR);
        add_text("GPGGA,");
        body_q.push_back(8'h00);
        body_q.push_back(8'hFF);
        add_text("9");
        send_sentence(CK_UPPER, 1'b0, END_LF);
        // a '$' in the middle throws away the sentence so far
        send_text("GPGGA,12", CK_MISSING, END_NONE);
        send_text("GPRMC,3", CK_UPPER, END_CR);
        // body buffer edge: 124 + '*' + two digits just fits, one more spills over
        repeat (124) body_q.push_back("7");
        send_sentence(CK_UPPER, 1'b0, END_CR);
        repeat (125) body_q.push_back("7");
        send_sentence(CK_UPPER, 1'b0, END_CR);
        // overlong then restarted by '$' without a terminator
        repeat (130) body_q.push_back(field_char());
        send_sentence(CK_UPPER, 1'b0, END_NONE);
        send_text("GPGSV,1,1", CK_LOWER, END_CR);

        // random part, mostly well-formed sentences with random content
        start_bytes = bytes_sent;
        offset = 0;
        while (offset < RANDOM_BYTES) begin
            if (offset >= 60 && !squeeze_req) begin
                // receiver holds off while back-to-back sentences pile up behind it
                tx_gaps     = 1'b0;
                squeeze_req = 1'b1;
                repeat (3) random_sentence(1'b1);
            end
            // idling by phase: both, receiver only, sender only, then none at the end
            tx_gaps    = !(offset >= 150 && offset < 220) && offset < 280;
            res_stalls = !(offset >= 220 && offset < 280) && offset < 280;
            if ($urandom_range(0, 99) < 8) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                random_sentence($urandom_range(0, 99) < 60);
            end
            offset = bytes_sent - start_bytes;
        end

        i_rx_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d rx words and %0d checked result words, %0d of them accepted",
                 bytes_sent, checked, accepted);
        $display("including a %0d-cycle receiver hold-off and overlong, bad and empty lines",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("** nmea_sentence_framer_checker: PASSED **");
        end else begin
            $display("** nmea_sentence_framer_checker: FAILED **");
        end
        $finish;
    end

endmodule
